FILE: hdl/fuzzy_subsequence_scorer_top_assert.svh
// Assertion macros shared by the fuzzy subsequence scorer.
`ifndef FUZZY_SUBSEQUENCE_SCORER_TOP_ASSERT_SVH
`define FUZZY_SUBSEQUENCE_SCORER_TOP_ASSERT_SVH

// Checked on every rising edge outside reset.
`define FSS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define FSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/fss_pkg.sv
// Package with the constants, types and character helpers of the fuzzy subsequence scorer.
`timescale 1ns / 1ps

package fss_pkg;

   localparam int MAX_QUERY       = 16;
   localparam int MAX_CAND_LEN    = 4096;
   localparam int QUERY_IDX_WIDTH = $clog2(MAX_QUERY);
   localparam int QLEN_WIDTH      = 5;
   localparam int BYTE_POS_WIDTH  = 13;
   localparam int SCORE_WIDTH     = 14;
   localparam int CHAR_WIDTH      = 8;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 64;
   localparam int RUN_BONUS       = 15;
   localparam int BOUNDARY_BONUS  = 10;
   localparam int LENGTH_SHIFT    = 3;

   typedef logic [CHAR_WIDTH-1:0]            char_type;
   typedef logic signed [SCORE_WIDTH-1:0]    score_type;
   typedef logic [BYTE_POS_WIDTH-1:0]        byte_pos_type;
   typedef logic [QLEN_WIDTH-1:0]            qlen_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_QUERY_LENGTH   = 2'd0,
      CSR_QUERY_CHARS_LO = 2'd1,
      CSR_QUERY_CHARS_HI = 2'd2
   } csr_index_type;

   function automatic logic is_upper(input char_type c);
      return c inside {[8'h41:8'h5a]};
   endfunction

   function automatic logic is_lower(input char_type c);
      return c inside {[8'h61:8'h7a]};
   endfunction

   function automatic logic is_digit(input char_type c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_alnum(input char_type c);
      return is_upper(c) || is_lower(c) || is_digit(c);
   endfunction

   function automatic char_type to_lower(input char_type c);
      return is_upper(c) ? char_type'(c + 8'd32) : c;
   endfunction

endpackage

FILE: hdl/fuzzy_subsequence_scorer_top.sv
// Top level of the fuzzy subsequence scorer: candidate byte stream in, one score per candidate out.
`timescale 1ns / 1ps

// The block takes one candidate byte per clock cycle, back to back, and scores the candidate
// against the query held in its registers. Each accepted transaction is captured in an input
// register; from there a single update (query character select, compare, gap and bonus add)
// advances the candidate state, and on the transaction marked last the result is loaded into the
// output register, which drives rsp_valid, once that register is free or being taken.
// A new byte is accepted every cycle while the output register is free or being taken; only a last
// byte waits for a result still held there. Write the query registers only while no candidate is
// in flight.
module fuzzy_subsequence_scorer_top (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic                                     req_has_char,
   input  logic [fss_pkg::CHAR_WIDTH-1:0]           req_char_byte,
   input  logic                                     req_last_byte,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic                                     rsp_matched,
   output logic signed [fss_pkg::SCORE_WIDTH-1:0]   rsp_score,
   output logic                                     rsp_overflow,
   input  logic                                     csr_write_enable,
   input  logic [fss_pkg::CSR_INDEX_WIDTH-1:0]      csr_index,
   input  logic [fss_pkg::CSR_DATA_WIDTH-1:0]       csr_write_data
);
   import fss_pkg::*;

   qlen_type                            query_length_ff;
   logic [CSR_DATA_WIDTH-1:0]           query_chars_lo_ff;
   logic [CSR_DATA_WIDTH-1:0]           query_chars_hi_ff;

   logic                                s1_valid_ff;
   logic                                s1_has_char_ff;
   char_type                            s1_char_ff;
   logic                                s1_last_ff;

   byte_pos_type                        byte_position_ff, byte_position_in;
   qlen_type                            query_index_ff, query_index_in;
   score_type                           last_match_ff, last_match_in;
   score_type                           running_score_ff, running_score_in;
   char_type                            previous_byte_ff, previous_byte_in;
   logic                                length_exceeded_ff, length_exceeded_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_matched_ff, rsp_matched_in;
   score_type                           rsp_score_ff, rsp_score_in;
   logic                                rsp_overflow_ff, rsp_overflow_in;

   logic                                s1_advance;
   qlen_type                            qlen_eff;
   logic [MAX_QUERY-1:0][CHAR_WIDTH-1:0] query_chars;
   char_type                            query_char;
   logic                                in_range;
   logic                                take_byte;
   logic                                is_match;
   logic                                boundary;
   score_type                           gap;
   score_type                           run_add;
   score_type                           bonus_add;
   byte_pos_type                        bp_upd;
   qlen_type                            qi_upd;
   score_type                           running_upd;
   logic                                exceeded_upd;
   logic                                query_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         query_length_ff   <= '0;
         query_chars_lo_ff <= '0;
         query_chars_hi_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_QUERY_LENGTH:   query_length_ff   <= csr_write_data[QLEN_WIDTH-1:0];
            CSR_QUERY_CHARS_LO: query_chars_lo_ff <= csr_write_data;
            CSR_QUERY_CHARS_HI: query_chars_hi_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign s1_advance = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_has_char_ff <= req_has_char;
         s1_char_ff     <= req_char_byte;
         s1_last_ff     <= req_last_byte;
      end
   end

   always_comb begin
      qlen_eff    = (query_length_ff > qlen_type'(MAX_QUERY)) ? qlen_type'(MAX_QUERY)
                                                              : query_length_ff;
      query_chars = {query_chars_hi_ff, query_chars_lo_ff};
      query_char  = query_chars[query_index_ff[QUERY_IDX_WIDTH-1:0]];
      in_range    = byte_position_ff < byte_pos_type'(MAX_CAND_LEN);
      take_byte   = s1_has_char_ff && in_range;
      is_match    = take_byte && (query_index_ff < qlen_eff) &&
                    (to_lower(s1_char_ff) == query_char);
      gap         = score_type'({1'b0, byte_position_ff}) - last_match_ff - score_type'(1);
      boundary    = (byte_position_ff == '0) || !is_alnum(previous_byte_ff) ||
                    (is_upper(s1_char_ff) && is_lower(previous_byte_ff));
      run_add     = (gap == '0) ? score_type'(RUN_BONUS) : -gap;
      bonus_add   = boundary ? score_type'(BOUNDARY_BONUS) : '0;

      bp_upd       = take_byte ? byte_pos_type'(byte_position_ff + 1'b1) : byte_position_ff;
      qi_upd       = is_match ? qlen_type'(query_index_ff + 1'b1) : query_index_ff;
      running_upd  = is_match ? score_type'(running_score_ff + run_add + bonus_add)
                              : running_score_ff;
      exceeded_upd = length_exceeded_ff || (s1_has_char_ff && !in_range);
      query_done   = qi_upd >= qlen_eff;

      rsp_matched_in  = query_done;
      rsp_score_in    = ((qlen_eff != '0) && query_done)
                        ? score_type'(running_upd -
                                      score_type'({1'b0, bp_upd >> LENGTH_SHIFT}))
                        : '0;
      rsp_overflow_in = exceeded_upd;

      if (s1_last_ff) begin
         byte_position_in   = '0;
         query_index_in     = '0;
         last_match_in      = score_type'(-1);
         running_score_in   = '0;
         previous_byte_in   = '0;
         length_exceeded_in = 1'b0;
      end else begin
         byte_position_in   = bp_upd;
         query_index_in     = qi_upd;
         last_match_in      = is_match ? score_type'({1'b0, byte_position_ff}) : last_match_ff;
         running_score_in   = running_upd;
         previous_byte_in   = take_byte ? s1_char_ff : previous_byte_ff;
         length_exceeded_in = exceeded_upd;
      end

      if (s1_advance && s1_last_ff) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff   <= '0;
         query_index_ff     <= '0;
         last_match_ff      <= score_type'(-1);
         running_score_ff   <= '0;
         previous_byte_ff   <= '0;
         length_exceeded_ff <= 1'b0;
      end else if (s1_advance) begin
         byte_position_ff   <= byte_position_in;
         query_index_ff     <= query_index_in;
         last_match_ff      <= last_match_in;
         running_score_ff   <= running_score_in;
         previous_byte_ff   <= previous_byte_in;
         length_exceeded_ff <= length_exceeded_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_last_ff) begin
         rsp_matched_ff  <= rsp_matched_in;
         rsp_score_ff    <= rsp_score_in;
         rsp_overflow_ff <= rsp_overflow_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_matched  = rsp_matched_ff;
   assign rsp_score    = rsp_score_ff;
   assign rsp_overflow = rsp_overflow_ff;

`include "fuzzy_subsequence_scorer_top_assert.svh"

   `FSS_ASSERT(a_unmatched_zero, clock, reset, (rsp_valid_ff && !rsp_matched_ff) |-> (rsp_score_ff == '0), "Unmatched transaction carries a non-zero score.")
   `FSS_ASSERT(a_query_index_bound, clock, reset, query_index_ff <= qlen_type'(MAX_QUERY), "Query index ran past the longest query.")
   `FSS_ASSERT(a_position_bound, clock, reset, byte_position_ff <= byte_pos_type'(MAX_CAND_LEN), "Byte position ran past the longest candidate.")
   `FSS_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> (!rsp_valid_ff && !s1_valid_ff), "Reset left a transaction pending.")

endmodule
